@@ hdl/escape_sequence_utf8_decoder_macros.svh @@
// assertion macros for the decoder top-level file
// each macro checks an implication on the rising edge of clock, ignored in reset
`ifndef ESCAPE_SEQUENCE_UTF8_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_UTF8_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ESUD_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("esud assertion failed");
// next-cycle implication
`define ESUD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("esud assertion failed");
`else
`define ESUD_ASSERT_NOW(name, ante, cons)
`define ESUD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hdl/esud_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package esud_pkg;

   // result queue sizing
   localparam int MAX_BURST    = 4;
   localparam int BURST_CNT_W  = $clog2(MAX_BURST + 1);
   localparam int QUEUE_DEPTH  = 8;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // one raw byte of the string body
   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } req_type;

   // one decoded result
   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_valid;
      logic       error;
      logic       string_end;
      logic       run_last;
   } rsp_type;

   // all results caused by one input byte, oldest in slot 0
   typedef struct packed {
      logic [BURST_CNT_W-1:0]  count;
      rsp_type [MAX_BURST-1:0] item;
   } burst_type;

endpackage

`default_nettype wire

@@ hdl/escape_sequence_utf8_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel      | ports                                 | moves
// -------------+---------------------------------------+------------------------------
// request      | req_valid, req_stall, req_payload     | one raw string byte
// response     | rsp_valid, rsp_stall, rsp_payload     | one decoded byte or error
//
// one byte accepted per cycle while req_stall is low; it yields 0 to 4 results,
// which enter an 8-entry result queue in the same edge and leave one per cycle
// from the queue head while rsp_stall is low.
// req_stall rises while fewer than 4 queue slots are free, so back-to-back
// multi-byte utf-8 output or a stalled consumer holds the input back.
// reset is synchronous and empties the queue and returns to plain text.

`include "escape_sequence_utf8_decoder_macros.svh"

module escape_sequence_utf8_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire esud_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output esud_pkg::rsp_type      rsp_payload
);

   localparam int PW = esud_pkg::QUEUE_PTR_W;
   localparam int CW = esud_pkg::QUEUE_CNT_W;

   esud_pkg::burst_type burst;
   esud_pkg::rsp_type   q_mem_ff [esud_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       q_cnt_ff, q_cnt_in;
   logic [CW-1:0]       add_cnt;
   logic                accept;
   logic                pop;

   // byte decoder with its escape state
   esud_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req_payload),
      .burst (burst)
   );

   // handshake
   assign req_stall   = q_cnt_ff > CW'(esud_pkg::QUEUE_DEPTH - esud_pkg::MAX_BURST);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = q_cnt_ff != '0;
   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_payload = q_mem_ff[rd_ptr_ff];

   // queue pointers and fill level
   always_comb begin
      add_cnt   = accept ? CW'(burst.count) : '0;
      wr_ptr_in = wr_ptr_ff + PW'(add_cnt);
      rd_ptr_in = rd_ptr_ff + (pop ? PW'(1) : PW'(0));
      q_cnt_in  = q_cnt_ff + add_cnt - (pop ? CW'(1) : CW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   // queue storage, burst written in order from the write pointer
   always_ff @(posedge clock) begin
      for (int k = 0; k < esud_pkg::MAX_BURST; k++) begin
         if (accept && (k < int'(burst.count))) begin
            q_mem_ff[wr_ptr_ff + PW'(k)] <= burst.item[k];
         end
      end
   end

   `ESUD_ASSERT_NOW(a_queue_bound, 1'b1, q_cnt_ff <= CW'(esud_pkg::QUEUE_DEPTH))
   `ESUD_ASSERT_NOW(a_error_closes, rsp_valid && rsp_payload.error, rsp_payload.string_end && !rsp_payload.byte_valid && rsp_payload.run_last)
   `ESUD_ASSERT_NEXT(a_idle_stays_empty, (q_cnt_ff == '0) && !accept, q_cnt_ff == '0)
   `ESUD_ASSERT_NOW(a_burst_closed, accept && (burst.count != '0), burst.item[2'(burst.count - 1'b1)].run_last)

endmodule

`default_nettype wire

@@ hdl/esud_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module esud_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire esud_pkg::req_type   req,
   output esud_pkg::burst_type      burst
);

   typedef enum logic [2:0] {
      MODE_TEXT = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_HEX  = 3'd2,
      MODE_UNI  = 3'd3,
      MODE_OCT  = 3'd4,
      MODE_SKIP = 3'd5
   } mode_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_V      = 8'h76;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_LU     = 8'h75;
   localparam logic [7:0] CH_UU     = 8'h55;

   // hex digit value, top bit marks a valid digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic esud_pkg::rsp_type mk(input logic [7:0] v, input logic ok,
                                            input logic err);
      esud_pkg::rsp_type r;
      r.byte_value = v;
      r.byte_valid = ok;
      r.error      = err;
      r.string_end = err;
      r.run_last   = 1'b0;
      return r;
   endfunction

   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        lu_ff, lu_in;

   logic [4:0]  hd;
   logic        is_oct;
   logic        enc_req;
   logic [esud_pkg::BURST_CNT_W-1:0] n;
   logic [1:0]  tail;
   esud_pkg::rsp_type [esud_pkg::MAX_BURST-1:0] items;

   assign hd     = hex_digit(req.char_in);
   assign is_oct = (req.char_in >= 8'h30) && (req.char_in <= 8'h37);

   // decode one byte: step, end-of-string handling, utf-8 encode, flags
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      lu_in   = lu_ff;
      enc_req = 1'b0;
      n       = '0;
      items   = '0;
      tail    = 2'd0;

      unique case (mode_ff)
         MODE_ESC: begin
            acc_in  = 32'd0;
            cnt_in  = 4'd0;
            mode_in = MODE_TEXT;
            unique case (req.char_in)
               CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: begin
                  items[n[1:0]] = mk(req.char_in, 1'b1, 1'b0); n = n + 1'b1;
               end
               CH_A: begin items[n[1:0]] = mk(8'h07, 1'b1, 1'b0); n = n + 1'b1; end
               CH_B: begin items[n[1:0]] = mk(8'h08, 1'b1, 1'b0); n = n + 1'b1; end
               CH_F: begin items[n[1:0]] = mk(8'h0C, 1'b1, 1'b0); n = n + 1'b1; end
               CH_N: begin items[n[1:0]] = mk(8'h0A, 1'b1, 1'b0); n = n + 1'b1; end
               CH_R: begin items[n[1:0]] = mk(8'h0D, 1'b1, 1'b0); n = n + 1'b1; end
               CH_T: begin items[n[1:0]] = mk(8'h09, 1'b1, 1'b0); n = n + 1'b1; end
               CH_V: begin items[n[1:0]] = mk(8'h0B, 1'b1, 1'b0); n = n + 1'b1; end
               CH_X:  mode_in = MODE_HEX;
               CH_LU: begin lu_in = 1'b0; mode_in = MODE_UNI; end
               CH_UU: begin lu_in = 1'b1; mode_in = MODE_UNI; end
               default: begin
                  if (is_oct) begin
                     acc_in  = {29'd0, req.char_in[2:0]};
                     cnt_in  = 4'd1;
                     mode_in = MODE_OCT;
                  end else begin
                     items[n[1:0]] = mk(8'h00, 1'b0, 1'b1); n = n + 1'b1;
                     mode_in = MODE_SKIP;
                  end
               end
            endcase
         end
         MODE_HEX: begin
            if (hd[4]) begin
               acc_in = {acc_ff[27:0], hd[3:0]};
               if (cnt_ff != 4'd15) cnt_in = cnt_ff + 4'd1;
            end else if (cnt_ff == 4'd0) begin
               items[n[1:0]] = mk(8'h00, 1'b0, 1'b1); n = n + 1'b1;
               mode_in = MODE_SKIP;
            end else begin
               items[n[1:0]] = mk(acc_ff[7:0], 1'b1, 1'b0); n = n + 1'b1;
               mode_in = MODE_TEXT;
               if (req.char_in == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  items[n[1:0]] = mk(req.char_in, 1'b1, 1'b0); n = n + 1'b1;
               end
            end
         end
         MODE_UNI: begin
            if (!hd[4]) begin
               items[n[1:0]] = mk(8'h00, 1'b0, 1'b1); n = n + 1'b1;
               mode_in = MODE_SKIP;
            end else begin
               acc_in = {acc_ff[27:0], hd[3:0]};
               cnt_in = cnt_ff + 4'd1;
               if (cnt_in >= (lu_ff ? 4'd8 : 4'd4)) enc_req = 1'b1;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               acc_in = {acc_ff[28:0], req.char_in[2:0]};
               cnt_in = cnt_ff + 4'd1;
               if (cnt_in >= 4'd3) begin
                  items[n[1:0]] = mk(acc_in[7:0], 1'b1, 1'b0); n = n + 1'b1;
                  mode_in = MODE_TEXT;
               end
            end else begin
               items[n[1:0]] = mk(acc_ff[7:0], 1'b1, 1'b0); n = n + 1'b1;
               mode_in = MODE_TEXT;
               if (req.char_in == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  items[n[1:0]] = mk(req.char_in, 1'b1, 1'b0); n = n + 1'b1;
               end
            end
         end
         MODE_SKIP: begin
            mode_in = MODE_SKIP;
         end
         default: begin
            mode_in = MODE_TEXT;
            if (req.char_in == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               items[n[1:0]] = mk(req.char_in, 1'b1, 1'b0); n = n + 1'b1;
            end
         end
      endcase

      // flush an open escape at the end of the string
      if (req.is_last) begin
         unique case (mode_in)
            MODE_ESC: begin
               items[n[1:0]] = mk(8'h00, 1'b0, 1'b1); n = n + 1'b1;
            end
            MODE_HEX: begin
               if (cnt_in == 4'd0) begin
                  items[n[1:0]] = mk(8'h00, 1'b0, 1'b1); n = n + 1'b1;
               end else begin
                  items[n[1:0]] = mk(acc_in[7:0], 1'b1, 1'b0); n = n + 1'b1;
               end
            end
            MODE_UNI: enc_req = 1'b1;
            MODE_OCT: begin
               items[n[1:0]] = mk(acc_in[7:0], 1'b1, 1'b0); n = n + 1'b1;
            end
            default: ;
         endcase
      end

      // utf-8 encode of a universal character name
      if (enc_req) begin
         mode_in = MODE_TEXT;
         if (acc_in <= 32'h7F) begin
            items[n[1:0]] = mk(acc_in[7:0], 1'b1, 1'b0); n = n + 1'b1;
         end else if (acc_in <= 32'h7FF) begin
            items[n[1:0]] = mk(8'hC0 | {3'd0, acc_in[10:6]}, 1'b1, 1'b0); n = n + 1'b1;
            items[n[1:0]] = mk(8'h80 | {2'd0, acc_in[5:0]}, 1'b1, 1'b0);  n = n + 1'b1;
         end else if (acc_in <= 32'hFFFF) begin
            items[n[1:0]] = mk(8'hE0 | {4'd0, acc_in[15:12]}, 1'b1, 1'b0); n = n + 1'b1;
            items[n[1:0]] = mk(8'h80 | {2'd0, acc_in[11:6]}, 1'b1, 1'b0);  n = n + 1'b1;
            items[n[1:0]] = mk(8'h80 | {2'd0, acc_in[5:0]}, 1'b1, 1'b0);   n = n + 1'b1;
         end else if (acc_in <= 32'h10FFFF) begin
            items[n[1:0]] = mk(8'hF0 | {5'd0, acc_in[20:18]}, 1'b1, 1'b0); n = n + 1'b1;
            items[n[1:0]] = mk(8'h80 | {2'd0, acc_in[17:12]}, 1'b1, 1'b0); n = n + 1'b1;
            items[n[1:0]] = mk(8'h80 | {2'd0, acc_in[11:6]}, 1'b1, 1'b0);  n = n + 1'b1;
            items[n[1:0]] = mk(8'h80 | {2'd0, acc_in[5:0]}, 1'b1, 1'b0);   n = n + 1'b1;
         end else begin
            items[n[1:0]] = mk(8'h00, 1'b0, 1'b1); n = n + 1'b1;
            mode_in = MODE_SKIP;
         end
      end

      // back to plain text after the final byte
      if (req.is_last) begin
         mode_in = MODE_TEXT;
         acc_in  = 32'd0;
         cnt_in  = 4'd0;
         lu_in   = 1'b0;
      end

      // mark the closing result of this byte and of the string
      if (n != '0) begin
         tail = n[1:0] - 2'd1;
         items[tail].run_last   = 1'b1;
         items[tail].string_end = items[tail].string_end | req.is_last;
      end
   end

   assign burst.count = n;
   assign burst.item  = items;

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         acc_ff  <= 32'd0;
         cnt_ff  <= 4'd0;
         lu_ff   <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         lu_ff   <= lu_in;
      end
   end

endmodule

`default_nettype wire
